// ===== hdl/srecord_line_decoder_core_assert.svh =====
// Assertion helpers shared by the decoder RTL.
// Each macro expects clk and rst to be visible at the point of use.
`ifndef SRECORD_LINE_DECODER_CORE_ASSERT_SVH
`define SRECORD_LINE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SRLD_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define SRLD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/srld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srld_pkg
// Shared types, character codes and helpers of the S-record line decoder.
// ----------------------------------------------------------------------------
package srld_pkg;

  localparam int MAX_LINE_CHARS_DEF = 516;

  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_S_UP = 8'h53;
  localparam logic [7:0] CHAR_S_LO = 8'h73;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_1    = 8'h31;
  localparam logic [7:0] CHAR_2    = 8'h32;
  localparam logic [7:0] CHAR_3    = 8'h33;
  localparam logic [7:0] CHAR_7    = 8'h37;
  localparam logic [7:0] CHAR_8    = 8'h38;
  localparam logic [7:0] CHAR_9    = 8'h39;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    REC_S0    = 3'd0,
    REC_S1    = 3'd1,
    REC_S2    = 3'd2,
    REC_S3    = 3'd3,
    REC_S7    = 3'd4,
    REC_S8    = 3'd5,
    REC_S9    = 3'd6,
    REC_OTHER = 3'd7
  } rec_type_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] byte_address;
    logic [7:0]  data_byte;
    logic [2:0]  record_type;
    logic        record_ok;
    logic [7:0]  data_count;
  } result_t;

  // Nibble value in [3:0]; bit 4 set for a non-hex character.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      v = 5'(c - 8'h30);
    end else if (c inside {[8'h41:8'h46]}) begin
      v = 5'(c - 8'h37);
    end else if (c inside {[8'h61:8'h66]}) begin
      v = 5'(c - 8'h57);
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/srld_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srld_in_stage
// Input register: holds one character until the decoder consumes it.
// ----------------------------------------------------------------------------
module srld_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_code,
  input  wire logic       consume,
  output logic            held_valid,
  output logic [7:0]      held_char
);

  // Take a new transaction when empty or when the held one leaves this cycle.
  assign in_ready = !held_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_char <= char_code;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/srld_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srld_decoder
// Per-line state and single-pass decode of one character into at most one
// result (data byte or end of line verdict).
// ----------------------------------------------------------------------------
module srld_decoder #(
  parameter int MAX_LINE_CHARS = srld_pkg::MAX_LINE_CHARS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        char_code,
  input  wire logic [31:0]       address_offset,
  output logic                   has_result,
  output srld_pkg::result_t      result
);
  import srld_pkg::*;
  `include "srecord_line_decoder_core_assert.svh"

  localparam int POS_W = $clog2(MAX_LINE_CHARS);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE_CHARS - 1);

  typedef struct packed {
    logic [POS_W-1:0] char_position;
    rec_type_t        line_type;
    logic [7:0]       byte_count;
    logic [3:0]       first_nibble;
    logic [7:0]       running_sum;
    logic [31:0]      record_address;
    logic             checksum_match;
    logic [7:0]       data_index;
    logic             lead_is_s;
  } line_state_t;

  line_state_t st;
  line_state_t st_next;
  line_state_t line_clear;

  logic             is_term;
  logic             overlong;
  logic             is_data;
  logic [2:0]       alen;
  logic             line_ok;
  logic [7:0]       line_cnt;
  logic [POS_W-1:0] off;
  logic [10:0]      k;
  logic [4:0]       hv;
  logic [7:0]       pair_byte;
  result_t          verdict;
  rec_type_t        digit_type;

  always_comb begin
    line_clear           = '0;
    line_clear.line_type = REC_OTHER;
  end

  assign is_term  = (char_code == CHAR_LF) || (char_code == CHAR_CR);
  assign overlong = (st.char_position >= POS_LAST);
  assign is_data  = (st.line_type == REC_S1) || (st.line_type == REC_S2) ||
                    (st.line_type == REC_S3);
  assign alen     = 3'(st.line_type) + 3'd1;

  // Good line: count covers address + checksum, checksum pair arrived, sum ok.
  assign line_ok  = is_data &&
                    (11'(st.byte_count) >= 11'(alen) + 11'd1) &&
                    (11'(st.char_position) >= 11'd4 + {2'b00, st.byte_count, 1'b0}) &&
                    st.checksum_match;
  assign line_cnt = st.byte_count - 8'(alen) - 8'd1;

  assign off       = st.char_position - POS_W'(2);
  assign k         = 11'(off[POS_W-1:1]);
  assign hv        = hex_value(char_code);
  assign pair_byte = hv[4] ? {4'h0, st.first_nibble} : {st.first_nibble, hv[3:0]};

  always_comb begin
    verdict              = '0;
    verdict.kind         = KIND_VERDICT;
    verdict.record_type  = 3'(st.line_type);
    verdict.record_ok    = line_ok;
    verdict.data_count   = line_ok ? line_cnt : 8'd0;
  end

  always_comb begin
    case (char_code)
      CHAR_0:  digit_type = REC_S0;
      CHAR_1:  digit_type = REC_S1;
      CHAR_2:  digit_type = REC_S2;
      CHAR_3:  digit_type = REC_S3;
      CHAR_7:  digit_type = REC_S7;
      CHAR_8:  digit_type = REC_S8;
      CHAR_9:  digit_type = REC_S9;
      default: digit_type = REC_OTHER;
    endcase
  end

  always_comb begin
    st_next    = st;
    has_result = 1'b0;
    result     = '0;
    if (step) begin
      if (is_term) begin
        if (st.char_position != '0) begin
          has_result = 1'b1;
          result     = verdict;
          st_next    = line_clear;
        end
      end else if (overlong || st.char_position == '0) begin
        // Close an overlong line first; this character opens the next one.
        if (overlong) begin
          has_result = 1'b1;
          result     = verdict;
        end
        st_next               = line_clear;
        st_next.char_position = POS_W'(1);
        st_next.lead_is_s     = (char_code == CHAR_S_UP) || (char_code == CHAR_S_LO);
      end else begin
        st_next.char_position = st.char_position + POS_W'(1);
        if (st.char_position == POS_W'(1)) begin
          st_next.line_type = st.lead_is_s ? digit_type : REC_OTHER;
        end else if (!off[0]) begin
          st_next.first_nibble = hv[4] ? 4'h0 : hv[3:0];
        end else if (k == 11'd0) begin
          st_next.byte_count  = pair_byte;
          st_next.running_sum = pair_byte;
        end else if (k < 11'(st.byte_count)) begin
          st_next.running_sum = st.running_sum + pair_byte;
          if (is_data) begin
            if (k <= 11'(alen)) begin
              st_next.record_address = {st.record_address[23:0], pair_byte};
            end else begin
              has_result          = 1'b1;
              result.kind         = KIND_DATA;
              result.byte_address = st.record_address + 32'(st.data_index) +
                                    address_offset;
              result.data_byte    = pair_byte;
              result.record_type  = 3'(st.line_type);
              st_next.data_index  = st.data_index + 8'd1;
            end
          end
        end else if (k == 11'(st.byte_count)) begin
          st_next.checksum_match = (~st.running_sum == pair_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= line_clear;
    end else begin
      st <= st_next;
    end
  end

  `SRLD_ASSERT_NEXT(a_term_clears, step && is_term, st.char_position == '0, "line not cleared at terminator")
  `SRLD_ASSERT_NOW(a_pos_bound, 1'b1, st.char_position <= POS_LAST, "char position past line limit")
  `SRLD_ASSERT_NOW(a_data_fields, has_result && result.kind == KIND_DATA, !result.record_ok && result.data_count == 8'd0 && is_data, "data result with verdict fields")
  `SRLD_ASSERT_NOW(a_count_ok, has_result && result.kind == KIND_VERDICT && !result.record_ok, result.data_count == 8'd0, "count on a rejected line")

endmodule
`default_nettype wire

// ===== hdl/srld_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srld_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module srld_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire srld_pkg::result_t result,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   kind,
  output logic [31:0]            byte_address,
  output logic [7:0]             data_byte,
  output logic [2:0]             record_type,
  output logic                   record_ok,
  output logic [7:0]             data_count
);
  import srld_pkg::*;
  `include "srecord_line_decoder_core_assert.svh"

  result_t held;

  // Free now, or freed by the transaction leaving this cycle.
  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && room) begin
      held <= result;
    end
  end

  assign kind         = held.kind;
  assign byte_address = held.byte_address;
  assign data_byte    = held.data_byte;
  assign record_type  = held.record_type;
  assign record_ok    = held.record_ok;
  assign data_count   = held.data_count;

  `SRLD_ASSERT_NEXT(a_load_shows, load && room, out_valid, "loaded result not presented")

endmodule
`default_nettype wire

// ===== hdl/srecord_line_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srecord_line_decoder_core
// S-record text decoder: characters in, data bytes and line verdicts out.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one character per transaction (char_code).
//   out_valid/out_ready carry results: kind 0 is a data byte with its
//   target address, kind 1 is the end of line verdict (type, ok, count).
//   cfg_valid/cfg_ready write address_offset; write it only while idle.
//   Each character causes zero or one result; empty lines give none.
//   A result is decoded out of the input register into the result register
//   by the single decode pass between the two registers. Throughput: one
//   character per cycle while the result register has room.
//   When the receiver stalls, the result register holds its transaction and
//   one more character waits in the input register; in_ready then drops.
//   Reset (rst, synchronous) clears the line state, empties both registers
//   and sets address_offset to zero.
//   Lines longer than MAX_LINE_CHARS - 1 characters are closed with a
//   verdict and the extra character starts a new line.
// ----------------------------------------------------------------------------
module srecord_line_decoder_core #(
  parameter int MAX_LINE_CHARS = srld_pkg::MAX_LINE_CHARS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [31:0]      byte_address,
  output logic [7:0]       data_byte,
  output logic [2:0]       record_type,
  output logic             record_ok,
  output logic [7:0]       data_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] address_offset
);
  import srld_pkg::*;

  logic        held_valid;
  logic [7:0]  held_char;
  logic        room;
  logic        step;
  logic        has_result;
  result_t     result;
  logic [31:0] offset;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      offset <= address_offset;
    end
  end

  // Advance the held character only when the result register can take it.
  assign step = held_valid && room;

  srld_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .consume    (step),
    .held_valid (held_valid),
    .held_char  (held_char)
  );

  srld_decoder #(
    .MAX_LINE_CHARS (MAX_LINE_CHARS)
  ) u_dec (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .char_code      (held_char),
    .address_offset (offset),
    .has_result     (has_result),
    .result         (result)
  );

  srld_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (step && has_result),
    .result       (result),
    .room         (room),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .byte_address (byte_address),
    .data_byte    (data_byte),
    .record_type  (record_type),
    .record_ok    (record_ok),
    .data_count   (data_count)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the S-record line decoder. Record text, mostly
// well-formed lines with random content plus damaged lines and noise, is
// streamed in one character per transaction. An internal line decoder
// predicts every data byte and end of line verdict, and the monitor compares
// each result field by field. Both handshakes idle at random, the receiver
// holds off for long stretches, and the address offset is rewritten between
// phases, including both extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import srld_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 150;
  localparam int MAX_LINE     = MAX_LINE_CHARS_DEF;

  typedef enum int {
    FLAW_NONE,
    FLAW_CSUM,
    FLAW_SHORT,
    FLAW_SMALL_COUNT,
    FLAW_TRAIL,
    FLAW_NON_HEX
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_code = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [31:0] byte_address;
  logic [7:0]  data_byte;
  logic [2:0]  record_type;
  logic        record_ok;
  logic [7:0]  data_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] address_offset = '0;

  srecord_line_decoder_core u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_code      (char_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .byte_address   (byte_address),
    .data_byte      (data_byte),
    .record_type    (record_type),
    .record_ok      (record_ok),
    .data_count     (data_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .address_offset (address_offset)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [7:0] text_q[$];
  result_t    decoded_q[$];
  int         chars_sent = 0;
  int         mismatches = 0;
  int         hold_left = 0;
  int         next_hold_at = 200;
  int         idle_cycles = 0;
  result_t    want;

  // No random idling on either side inside this window; the long receiver holds still apply.
  wire quiet = (chars_sent >= 900) && (chars_sent < 1250);

  // --------------------------------------------------------------------------
  // Line decoder shadow
  // --------------------------------------------------------------------------
  int          line_pos;
  rec_type_t   line_kind;
  logic [7:0]  line_count;
  logic [7:0]  line_sum;
  logic [7:0]  line_idx;
  logic [3:0]  line_hi;
  logic [31:0] line_addr;
  logic        line_sum_ok;
  logic        line_lead_s;
  logic [31:0] offset_shadow;

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      return {1'b0, c[3:0] + 4'd9};
    end
    return 5'h10;
  endfunction

  function automatic bit is_data_line();
    return line_kind == REC_S1 || line_kind == REC_S2 || line_kind == REC_S3;
  endfunction

  function automatic void reset_line();
    line_pos    = 0;
    line_kind   = REC_OTHER;
    line_count  = '0;
    line_sum    = '0;
    line_idx    = '0;
    line_hi     = '0;
    line_addr   = '0;
    line_sum_ok = 1'b0;
    line_lead_s = 1'b0;
  endfunction

  function automatic void close_line();
    result_t r;
    int      alen;
    r = '0;
    r.kind = KIND_VERDICT;
    r.record_type = line_kind;
    if (is_data_line()) begin
      alen = int'(line_kind) + 1;
      if (int'(line_count) >= alen + 1 && line_pos >= 2 + 2 * (int'(line_count) + 1) &&
          line_sum_ok) begin
        r.record_ok = 1'b1;
        r.data_count = 8'(int'(line_count) - alen - 1);
      end
    end
    decoded_q.push_back(r);
    reset_line();
  endfunction

  function automatic void decode_char(input logic [7:0] c);
    result_t    r;
    int         off;
    int         k;
    int         alen;
    logic [4:0] v;
    logic [7:0] b;
    if (c == CHAR_LF || c == CHAR_CR) begin
      // an empty line gives nothing
      if (line_pos != 0) close_line();
    end else begin
      // an overlong line is closed first; this character opens the next one
      if (line_pos >= MAX_LINE - 1) close_line();
      if (line_pos == 0) begin
        line_lead_s = (c == CHAR_S_UP || c == CHAR_S_LO);
      end else if (line_pos == 1) begin
        line_kind = REC_OTHER;
        if (line_lead_s) begin
          case (c)
            CHAR_0: line_kind = REC_S0;
            CHAR_1: line_kind = REC_S1;
            CHAR_2: line_kind = REC_S2;
            CHAR_3: line_kind = REC_S3;
            CHAR_7: line_kind = REC_S7;
            CHAR_8: line_kind = REC_S8;
            CHAR_9: line_kind = REC_S9;
            default: line_kind = REC_OTHER;
          endcase
        end
      end else begin
        off = line_pos - 2;
        k = off / 2;
        v = nibble_of(c);
        if (off % 2 == 0) begin
          line_hi = v[4] ? 4'd0 : v[3:0];
        end else begin
          b = v[4] ? {4'd0, line_hi} : {line_hi, v[3:0]};
          if (k == 0) begin
            line_count = b;
            line_sum = b;
          end else if (k < int'(line_count)) begin
            line_sum = line_sum + b;
            if (is_data_line()) begin
              alen = int'(line_kind) + 1;
              if (k <= alen) begin
                line_addr = {line_addr[23:0], b};
              end else begin
                r = '0;
                r.kind = KIND_DATA;
                r.byte_address = line_addr + 32'(line_idx) + offset_shadow;
                r.data_byte = b;
                r.record_type = line_kind;
                decoded_q.push_back(r);
                line_idx = line_idx + 8'd1;
              end
            end
          end else if (k == int'(line_count)) begin
            line_sum_ok = (~line_sum == b);
          end
        end
      end
      line_pos = line_pos + 1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Record text generation
  // --------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 4'd10) return CHAR_0 + 8'(nib);
    return (lower ? 8'h57 : 8'h37) + 8'(nib);
  endfunction

  // Any character but a line end; with hex_ok clear, never a hex digit.
  function automatic logic [7:0] junk_char(input bit hex_ok);
    logic [7:0] c;
    logic [4:0] v;
    do begin
      c = 8'($urandom);
      v = nibble_of(c);
    end while (c == CHAR_LF || c == CHAR_CR || (!hex_ok && !v[4]));
    return c;
  endfunction

  function automatic void push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void push_line_end();
    case ($urandom_range(0, 2))
      0: text_q.push_back(CHAR_LF);
      1: text_q.push_back(CHAR_CR);
      default: begin
        text_q.push_back(CHAR_CR);
        text_q.push_back(CHAR_LF);
      end
    endcase
  endfunction

  function automatic void push_record(input rec_type_t rt, input logic [31:0] addr,
                                      input int ndata, input flaw_t flaw);
    logic [7:0] bytes[$];
    logic [7:0] line[$];
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] digit;
    int         alen;
    int         n;
    int         i;
    bit         lower;
    case (rt)
      REC_S2, REC_S8: alen = 3;
      REC_S3, REC_S7: alen = 4;
      default: alen = 2;
    endcase
    case (rt)
      REC_S0: digit = CHAR_0;
      REC_S1: digit = CHAR_1;
      REC_S2: digit = CHAR_2;
      REC_S3: digit = CHAR_3;
      REC_S7: digit = CHAR_7;
      REC_S8: digit = CHAR_8;
      default: digit = CHAR_9;
    endcase
    n = (ndata > 254 - alen) ? 254 - alen : ndata;
    bytes.push_back(8'(alen + n + 1));
    for (i = alen - 1; i >= 0; i--) bytes.push_back(addr[8 * i +: 8]);
    for (i = 0; i < n; i++) bytes.push_back(8'($urandom));
    sum = '0;
    foreach (bytes[i]) sum = sum + bytes[i];
    bytes.push_back(~sum);
    if (flaw == FLAW_CSUM) bytes[bytes.size() - 1] ^= 8'($urandom_range(1, 255));
    if (flaw == FLAW_SMALL_COUNT) bytes[0] = 8'($urandom_range(0, alen));
    lower = 1'($urandom_range(0, 1));
    line.push_back($urandom_range(0, 1) ? CHAR_S_LO : CHAR_S_UP);
    line.push_back(digit);
    foreach (bytes[i]) begin
      b = bytes[i];
      line.push_back(hex_char(b[7:4], lower));
      line.push_back(hex_char(b[3:0], lower));
    end
    if (flaw == FLAW_NON_HEX) line[$urandom_range(2, line.size() - 1)] = junk_char(1'b0);
    if (flaw == FLAW_SHORT) repeat ($urandom_range(1, 3)) void'(line.pop_back());
    if (flaw == FLAW_TRAIL) repeat ($urandom_range(1, 6)) line.push_back(junk_char(1'b1));
    foreach (line[i]) text_q.push_back(line[i]);
    push_line_end();
  endfunction

  function automatic void push_random_lines(input int target);
    int        added;
    int        before_size;
    int        pick;
    int        ndata;
    rec_type_t rt;
    flaw_t     flaw;
    added = 0;
    while (added < target) begin
      before_size = text_q.size();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        rt = rec_type_t'($urandom_range(1, 3));
        ndata = ($urandom_range(0, 99) < 2) ? 255 : $urandom_range(0, 16);
        flaw = ($urandom_range(0, 99) < 20) ? flaw_t'($urandom_range(1, 5)) : FLAW_NONE;
        push_record(rt, $urandom, ndata, flaw);
      end else if (pick < 82) begin
        rt = rec_type_t'($urandom_range(3, 6));
        if (rt == REC_S3) rt = REC_S0;
        push_record(rt, $urandom, $urandom_range(0, 8), FLAW_NONE);
      end else begin
        repeat ($urandom_range(0, 12)) text_q.push_back(junk_char(1'b1));
        push_line_end();
      end
      added += text_q.size() - before_size;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Character driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      char_code <= '0;
    end else begin
      if (in_valid && in_ready) begin
        decode_char(char_code);
        chars_sent <= chars_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (text_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 16)) begin
          in_valid <= 1'b1;
          char_code <= text_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result acceptance: random idling plus a long hold every few hundred characters.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (chars_sent >= next_hold_at) begin
      hold_left <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + 500;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 16);
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (mismatches < 100) begin
      $display("mismatch on %s: got %0h, predicted %0h (t=%0t)", field, got, exp_val,
               $realtime);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unpredicted transaction", {31'd0, kind}, 32'd0);
      end else begin
        want = decoded_q.pop_front();
        if (kind !== want.kind) report_mismatch("kind", 32'(kind), 32'(want.kind));
        if (byte_address !== want.byte_address)
          report_mismatch("byte_address", byte_address, want.byte_address);
        if (data_byte !== want.data_byte)
          report_mismatch("data_byte", 32'(data_byte), 32'(want.data_byte));
        if (record_type !== want.record_type)
          report_mismatch("record_type", 32'(record_type), 32'(want.record_type));
        if (record_ok !== want.record_ok)
          report_mismatch("record_ok", 32'(record_ok), 32'(want.record_ok));
        if (data_count !== want.data_count)
          report_mismatch("data_count", 32'(data_count), 32'(want.data_count));
      end
    end
  end

  // Abort when no transaction moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing
  // --------------------------------------------------------------------------
  task automatic write_offset(input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    address_offset <= value;
    do @(posedge clk); while (!cfg_ready);
    offset_shadow = value;
    cfg_valid <= 1'b0;
  endtask

  // Hold the sender until every predicted result is out and the pipe is empty.
  task automatic wait_drained();
    do @(negedge clk); while (text_q.size() != 0 || in_valid || decoded_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          phase;
    int          i;
    logic [31:0] offset_value;
    reset_line();
    offset_shadow = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_offset(32'h0);
    @(negedge clk);

    push_text("\n");
    push_record(REC_S1, 32'h0, 0, FLAW_NONE);
    push_record(REC_S1, 32'hFFFF, 2, FLAW_NONE);
    push_record(REC_S2, 32'hFF_FFFF, 3, FLAW_NONE);
    push_record(REC_S3, 32'hFFFF_FFFF, 4, FLAW_NONE);
    push_record(REC_S0, 32'h0, 4, FLAW_NONE);
    push_record(REC_S7, 32'h1234_5678, 0, FLAW_NONE);
    push_record(REC_S8, 32'h00AB_CDEF, 0, FLAW_NONE);
    push_record(REC_S9, 32'h0000_8000, 0, FLAW_NONE);
    push_text("X1030000FC\n");
    push_text("S5030000FC\r\n");
    push_text("s1050010abcd72\n");
    push_text("S1050000G5z.F5\r");
    push_record(REC_S1, $urandom, 3, FLAW_SMALL_COUNT);
    push_record(REC_S2, $urandom, 2, FLAW_SHORT);
    push_text("S\n");
    push_record(REC_S3, $urandom, 2, FLAW_TRAIL);
    push_record(REC_S1, $urandom, 2, FLAW_CSUM);
    push_record(REC_S2, $urandom, 3, FLAW_NON_HEX);
    push_record(REC_S1, 32'h0, 255, FLAW_NONE);
    text_q.push_back(8'hFF);
    text_q.push_back(8'h00);
    text_q.push_back(CHAR_LF);
    // overlong line: closes itself and spills into a new line
    push_text("S1");
    for (i = 0; i < 520; i++) text_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
    text_q.push_back(CHAR_LF);

    for (phase = 0; phase < 6; phase++) begin
      wait_drained();
      case (phase)
        0: offset_value = 32'hFFFF_FFFF;
        1: offset_value = $urandom;
        2: offset_value = 32'h1;
        3: offset_value = 32'h8000_0000;
        4: offset_value = $urandom;
        default: offset_value = 32'h0;
      endcase
      write_offset(offset_value);
      @(negedge clk);
      push_random_lines(30);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/srld_pkg.sv
hdl/srld_in_stage.sv
hdl/srld_decoder.sv
hdl/srld_out_stage.sv
hdl/srecord_line_decoder_core.sv
tb/tb_top.sv
